/* src/pidmc_pkg.sv */
package pidmc_pkg;

	localparam int unsigned GainW  = 16;
	localparam int unsigned ValW   = 16;
	localparam int unsigned IntW   = 12;
	localparam int unsigned CntW   = 14;
	localparam int unsigned MagW   = 13;
	localparam int unsigned OpAW   = 17;
	localparam int unsigned OpBW   = 18;
	localparam int unsigned ProdW  = OpAW + OpBW;
	localparam int unsigned AccW   = 24;
	localparam int unsigned GainSh = 12;
	localparam int unsigned ScaleSh = 14;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] CFG_KP = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_KI = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_KD = 2'd2;

	localparam logic [GainW-1:0] KpReset = 16'd819;
	localparam logic [GainW-1:0] KiReset = 16'd0;
	localparam logic [GainW-1:0] KdReset = 16'd614;

	localparam logic signed [16:0]     IntLimit   = 17'sd819;
	localparam logic signed [AccW-1:0] OutLimit   = 24'sd6062;
	localparam logic signed [OpAW-1:0] ScaleMul   = 17'sd19457;
	localparam logic [MagW-1:0]        CountLimit = 13'd7199;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MP,
		ST_MI,
		ST_MD,
		ST_SUM,
		ST_CLAMP,
		ST_SCALE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_P,
		OP_I,
		OP_D,
		OP_S
	} op_sel_t;

	typedef struct packed {
		op_sel_t op_sel;
		logic    mul_en;
		logic    acc_clr;
		logic    acc_en;
		logic    load_mag;
		logic    load_out;
	} ctl_t;

endpackage

/* src/pidmc_if.sv */
interface pidmc_in_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] target_value;
	logic signed [15:0] measured_value;

	modport source(output valid, output target_value, output measured_value, input ready);
	modport sink(input valid, input target_value, input measured_value, output ready);
endinterface

interface pidmc_out_if;
	logic              valid;
	logic              ready;
	logic signed [13:0] correction_counts;
	logic              output_saturated;

	modport source(output valid, output correction_counts, output output_saturated, input ready);
	modport sink(input valid, input correction_counts, input output_saturated, output ready);
endinterface

/* src/pid_motor_correction.sv */
// PID motor correction.
// in_ch carries target_value and measured_value (signed Q4.12); an item is
// taken when valid and ready are both high. out_ch returns one item per input:
// correction_counts (signed PWM compare counts) and output_saturated.
// Gains kp, ki, kd (unsigned Q4.12) are written on cfg_we with cfg_index 0, 1, 2;
// other indexes are ignored. Write gains only while the block is idle.
// Datapath: one shared 17x18 multiplier with an accumulator runs four products
// (kp, ki, kd terms and the count scaling) under a small sequencer. After
// acceptance an item passes the states MP, MI, MD, SUM, CLAMP, SCALE and DONE;
// its result is loaded into the output register from DONE. in_ch.ready is low
// from acceptance until that load. A result waiting in the output register
// does not block acceptance; only the final load waits if the receiver stalls.
// Reset returns gains to kp 819, ki 0, kd 614 and clears the previous error
// and the integral; ready is high and no result is pending after reset.
module pid_motor_correction (
	input  logic                            clk,
	input  logic                            arst_n,
	pidmc_in_if.sink                        in_ch,
	pidmc_out_if.source                     out_ch,
	input  logic                            cfg_we,
	input  logic [pidmc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [pidmc_pkg::GainW-1:0]     cfg_data
);
	import pidmc_pkg::*;

	logic [GainW-1:0] kp_q, ki_q, kd_q;
	logic signed [ValW-1:0] prev_err_q, err_q;
	logic signed [IntW-1:0] integ_q, integ_acc_q;
	logic signed [16:0]     diff_q;
	logic [MagW-1:0]        mag_q;
	logic                   neg_q, sat_q;
	logic                   out_valid_q;
	logic signed [CntW-1:0] counts_q;
	logic                   out_sat_q;

	state_t state_q;
	ctl_t   ctl;
	logic   in_fire, out_free;

	logic signed [16:0]     te_diff, isum, integ_c, dsum;
	logic signed [ValW-1:0] err_c;
	logic signed [OpAW-1:0] op_a;
	logic signed [OpBW-1:0] op_b;
	logic signed [ProdW-1:0] prod_q;
	logic signed [AccW-1:0]  acc_q, u_c;
	logic [MagW-1:0]        sc_mag;
	logic                   sat_c;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	pidmc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.out_free(out_free),
		.state_q (state_q),
		.ctl     (ctl)
	);

	// error, integral and derivative difference at acceptance
	always_comb begin
		te_diff = 17'(in_ch.target_value) - 17'(in_ch.measured_value);
		if (te_diff[16] != te_diff[15]) begin
			err_c = te_diff[16] ? 16'sh8000 : 16'sh7FFF;
		end else begin
			err_c = te_diff[15:0];
		end
		isum = 17'(integ_acc_q) + 17'(err_c);
		if (isum > IntLimit) begin
			integ_c = IntLimit;
		end else if (isum < -IntLimit) begin
			integ_c = -IntLimit;
		end else begin
			integ_c = isum;
		end
		dsum = 17'(err_c) - 17'(prev_err_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= KpReset;
			ki_q        <= KiReset;
			kd_q        <= KdReset;
			prev_err_q  <= '0;
			integ_acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_KP:  kp_q <= cfg_data;
					CFG_KI:  ki_q <= cfg_data;
					CFG_KD:  kd_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_fire) begin
				prev_err_q  <= err_c;
				integ_acc_q <= integ_c[IntW-1:0];
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_q   <= err_c;
			integ_q <= integ_c[IntW-1:0];
			diff_q  <= dsum;
		end
		if (ctl.load_mag) begin
			mag_q <= MagW'(u_c < 0 ? -u_c : u_c);
			neg_q <= u_c[AccW-1];
			sat_q <= sat_c;
		end
		if (ctl.load_out) begin
			counts_q  <= neg_q ? -CntW'(sc_mag) : CntW'(sc_mag);
			out_sat_q <= sat_q;
		end
	end

	always_comb begin
		unique case (ctl.op_sel)
			OP_P: begin
				op_a = OpAW'(kp_q);
				op_b = OpBW'(err_q);
			end
			OP_I: begin
				op_a = OpAW'(ki_q);
				op_b = OpBW'(integ_q);
			end
			OP_D: begin
				op_a = OpAW'(kd_q);
				op_b = OpBW'(diff_q);
			end
			OP_S: begin
				op_a = ScaleMul;
				op_b = OpBW'(mag_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	pidmc_mac u_mac (
		.clk   (clk),
		.ctl   (ctl),
		.op_a  (op_a),
		.op_b  (op_b),
		.prod_q(prod_q),
		.acc_q (acc_q)
	);

	// output clamp on the summed terms
	always_comb begin
		sat_c = (acc_q > OutLimit) || (acc_q < -OutLimit);
		if (acc_q > OutLimit) begin
			u_c = OutLimit;
		end else if (acc_q < -OutLimit) begin
			u_c = -OutLimit;
		end else begin
			u_c = acc_q;
		end
		sc_mag = prod_q[ScaleSh+MagW-1:ScaleSh];
		if (sc_mag > CountLimit) sc_mag = CountLimit;
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.correction_counts = counts_q;
	assign out_ch.output_saturated  = out_sat_q;

`ifndef NO_ASSERTIONS
	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		(integ_acc_q <= 12'sd819) && (integ_acc_q >= -12'sd819))
		else $error("integral outside its clamp");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_MP))
		else $error("accepted item did not start the sequence");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (state_q == ST_DONE) && out_free)
		else $error("output loaded outside the final step");

	a_sat_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_sat_q) |->
		(counts_q == 14'sd7198) || (counts_q == -14'sd7198))
		else $error("saturated item without full-scale counts");

	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ch.ready ##1 !in_ch.ready)
		else $error("ready raised during an item");
`endif

endmodule

/* src/pidmc_mac.sv */
module pidmc_mac (
	input  logic                                 clk,
	input  pidmc_pkg::ctl_t                      ctl,
	input  logic signed [pidmc_pkg::OpAW-1:0]    op_a,
	input  logic signed [pidmc_pkg::OpBW-1:0]    op_b,
	output logic signed [pidmc_pkg::ProdW-1:0]   prod_q,
	output logic signed [pidmc_pkg::AccW-1:0]    acc_q
);
	import pidmc_pkg::*;

	logic signed [ProdW-GainSh-1:0] term;

	// floor shift of the previous product
	assign term = prod_q[ProdW-1:GainSh];

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= ProdW'(op_a) * ProdW'(op_b);
		end
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + AccW'(term);
		end
	end

endmodule

/* src/pidmc_ctrl.sv */
module pidmc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_free,
	output pidmc_pkg::state_t state_q,
	output pidmc_pkg::ctl_t   ctl
);
	import pidmc_pkg::*;

	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '{op_sel: OP_P, default: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				ctl.acc_clr = 1'b1;
				if (in_fire) state_d = ST_MP;
			end
			ST_MP: begin
				ctl.op_sel = OP_P;
				ctl.mul_en = 1'b1;
				state_d    = ST_MI;
			end
			ST_MI: begin
				ctl.op_sel = OP_I;
				ctl.mul_en = 1'b1;
				ctl.acc_en = 1'b1;
				state_d    = ST_MD;
			end
			ST_MD: begin
				ctl.op_sel = OP_D;
				ctl.mul_en = 1'b1;
				ctl.acc_en = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				ctl.acc_en = 1'b1;
				state_d    = ST_CLAMP;
			end
			ST_CLAMP: begin
				ctl.load_mag = 1'b1;
				state_d      = ST_SCALE;
			end
			ST_SCALE: begin
				ctl.op_sel = OP_S;
				ctl.mul_en = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
